FILE: rtl/core/tmtw_pkg.sv
// tmtw_pkg: shared codes and types for the text mode terminal writer
// used by tmtw_apb_regs and text_mode_terminal_writer, no dependencies
package tmtw_pkg;

  // sequencer states of the cell memory controller
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCROLL,
    ST_FILL,
    ST_PUT,
    ST_RESULT
  } tmtw_state_t;

  // item actions
  localparam logic [1:0] ACT_PUT_CHAR = 2'd0;
  localparam logic [1:0] ACT_PUT_CELL = 2'd1;
  localparam logic [1:0] ACT_READ     = 2'd2;

  localparam logic [7:0] NEWLINE_CODE  = 8'd10;
  localparam logic [7:0] BLANK_CODE    = 8'd32;
  localparam logic [7:0] DEFAULT_COLOR = 8'd7;

  // apb register map: one 32-bit register per word
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0] REG_TEXT_COLOR = '0;

endpackage

FILE: rtl/core/text_mode_terminal_writer.sv
// text_mode_terminal_writer: text cell grid in one memory with a write cursor
// depends on tmtw_pkg and tmtw_apb_regs
//
// Usage:
//   Items enter on item_valid/item_stall with action, char_code, cell_color,
//   column and row; one result leaves per item on result_valid/result_stall
//   with cell_value, cursor_row, cursor_column and scrolled.
//   The grid lives in one ROWS*COLUMNS x 16 memory with a registered read.
//   Every item is handled by a small sequencer, one at a time.
//   An accepted item passes through the result state, which loads the
//   output register; the next item is taken only once it is back in idle.
//   A printable character with a scroll pending first moves the grid up one
//   row (one cell per cycle) and blanks the last row, then writes the
//   character into the bottom row.
//   After reset a clearing pass writes a blank in the default colour to all
//   ROWS*COLUMNS cells, one per cycle; item_stall is high meanwhile while
//   register writes are taken as ever.
//   When result_stall holds a result in the output register, the next item
//   is still accepted and worked on; only its result waits for the slot.
module text_mode_terminal_writer #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    action,
  input  logic [7:0]                    char_code,
  input  logic [7:0]                    cell_color,
  input  logic [6:0]                    column,
  input  logic [4:0]                    row,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [15:0]                   cell_value,
  output logic [4:0]                    cursor_row,
  output logic [6:0]                    cursor_column,
  output logic                          scrolled,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmtw_pkg::PADDR_W-1:0] paddr,
  input  logic [tmtw_pkg::PDATA_W-1:0] pwdata,
  output logic [tmtw_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import tmtw_pkg::*;

  localparam int CELL_COUNT = ROWS * COLUMNS;
  localparam int MOVE_COUNT = (ROWS - 1) * COLUMNS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int RW         = $clog2(ROWS + 1);
  localparam int CW         = $clog2(COLUMNS);

  tmtw_state_t state, state_next;

  logic [7:0]        text_color;
  logic [15:0]       mem [CELL_COUNT];
  logic [15:0]       rdata;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [15:0]       wr_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  logic [ADDR_W-1:0] idx;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     cur_col;
  logic [7:0]        hold_char;
  logic [15:0]       res_value;
  logic              res_from_mem;
  logic              res_scrolled;

  logic              accept;
  logic              take_slot;
  logic              row_pending;
  logic              is_newline;
  logic              in_range;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] pos_addr;
  logic [ADDR_W-1:0] bottom_addr;
  logic [RW-1:0]     adv_base_row;
  logic              wrap;
  logic [RW-1:0]     adv_row;
  logic [CW-1:0]     adv_col;

  tmtw_apb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .text_color (text_color)
  );

  assign item_stall  = (state != ST_IDLE);
  assign accept      = item_valid && !item_stall;
  assign take_slot   = !result_valid || !result_stall;
  assign row_pending = (cur_row == RW'(ROWS));
  assign is_newline  = (char_code == NEWLINE_CODE);
  assign in_range    = (int'(column) < COLUMNS) && (int'(row) < ROWS);

  assign cur_addr    = ADDR_W'(cur_row) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col);
  assign pos_addr    = ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(column);
  assign bottom_addr = ADDR_W'(MOVE_COUNT) + ADDR_W'(cur_col);

  // cursor advance, from the bottom row after a scroll
  assign adv_base_row = (state == ST_PUT) ? RW'(ROWS - 1) : cur_row;
  assign wrap         = (cur_col == CW'(COLUMNS - 1));
  assign adv_col      = wrap ? '0 : cur_col + 1'b1;
  assign adv_row      = wrap ? adv_base_row + 1'b1 : adv_base_row;

  // cell memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (idx == ADDR_W'(CELL_COUNT - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          if (action == ACT_PUT_CHAR && !is_newline && row_pending) begin
            state_next = ST_SCROLL;
          end else begin
            state_next = ST_RESULT;
          end
        end
      end
      ST_SCROLL: begin
        if (idx == ADDR_W'(MOVE_COUNT)) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (idx == ADDR_W'(CELL_COUNT - 1)) state_next = ST_PUT;
      end
      ST_PUT: begin
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (take_slot) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // memory port controls
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    rd_en   = 1'b0;
    rd_addr = '0;
    case (state)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = {DEFAULT_COLOR, BLANK_CODE};
      end
      ST_IDLE: begin
        if (accept) begin
          case (action)
            ACT_PUT_CHAR: begin
              if (!is_newline && !row_pending) begin
                wr_en   = 1'b1;
                wr_addr = cur_addr;
                wr_data = {text_color, char_code};
              end
            end
            ACT_PUT_CELL: begin
              if (in_range) begin
                wr_en   = 1'b1;
                wr_addr = pos_addr;
                wr_data = {cell_color, char_code};
              end
            end
            ACT_READ: begin
              if (in_range) begin
                rd_en   = 1'b1;
                rd_addr = pos_addr;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCROLL: begin
        // read one row ahead, write the word fetched last cycle one cell back
        rd_en   = (idx != ADDR_W'(MOVE_COUNT));
        rd_addr = idx + ADDR_W'(COLUMNS);
        wr_en   = (idx != '0);
        wr_addr = idx - 1'b1;
        wr_data = rdata;
      end
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = idx;
        wr_data = {text_color, BLANK_CODE};
      end
      ST_PUT: begin
        wr_en   = 1'b1;
        wr_addr = bottom_addr;
        wr_data = {text_color, hold_char};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      idx          <= '0;
      cur_row      <= '0;
      cur_col      <= '0;
      result_valid <= 1'b0;
      res_from_mem <= 1'b0;
      res_scrolled <= 1'b0;
    end else begin
      state <= state_next;

      // the result state sets the slot itself
      if (result_valid && !result_stall && state != ST_RESULT) begin
        result_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          idx <= (idx == ADDR_W'(CELL_COUNT - 1)) ? '0 : idx + 1'b1;
        end
        ST_IDLE: begin
          idx <= '0;
          if (accept) begin
            res_from_mem <= 1'b0;
            res_scrolled <= 1'b0;
            res_value    <= '0;
            hold_char    <= char_code;
            case (action)
              ACT_PUT_CHAR: begin
                if (is_newline) begin
                  cur_col <= '0;
                  if (!row_pending) cur_row <= cur_row + 1'b1;
                end else if (!row_pending) begin
                  cur_row   <= adv_row;
                  cur_col   <= adv_col;
                  res_value <= {text_color, char_code};
                end
              end
              ACT_PUT_CELL: begin
                if (in_range) res_value <= {cell_color, char_code};
              end
              ACT_READ: begin
                res_from_mem <= in_range;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (idx != ADDR_W'(MOVE_COUNT)) idx <= idx + 1'b1;
        end
        ST_FILL: begin
          idx <= (idx == ADDR_W'(CELL_COUNT - 1)) ? '0 : idx + 1'b1;
        end
        ST_PUT: begin
          cur_row      <= adv_row;
          cur_col      <= adv_col;
          res_value    <= {text_color, hold_char};
          res_scrolled <= 1'b1;
        end
        ST_RESULT: begin
          if (take_slot) begin
            result_valid  <= 1'b1;
            cell_value    <= res_from_mem ? rdata : res_value;
            cursor_row    <= 5'(cur_row);
            cursor_column <= 7'(cur_col);
            scrolled      <= res_scrolled;
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_row_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cur_row) <= ROWS)
    else $error("cursor row beyond the grid");

  a_col_bound: assert property (@(posedge clk) disable iff (rst)
    int'(cur_col) < COLUMNS)
    else $error("cursor column beyond the row end");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_stall)
    else $error("item taken while the previous one is still at work");

  a_scroll_row: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RESULT && res_scrolled) |-> int'(cur_row) >= ROWS - 1)
    else $error("scrolled item left the cursor above the bottom row");

endmodule

FILE: rtl/core/tmtw_apb_regs.sv
// tmtw_apb_regs: apb-style register port holding the text colour register
// depends on tmtw_pkg for the address map and reset colour
module tmtw_apb_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tmtw_pkg::PADDR_W-1:0] paddr,
  input  logic [tmtw_pkg::PDATA_W-1:0] pwdata,
  output logic [tmtw_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output logic [7:0]                    text_color
);
  import tmtw_pkg::*;

  logic hit_color;

  // low two address bits select a byte within the word and are ignored
  assign hit_color = (paddr[PADDR_W-1:2] == REG_TEXT_COLOR);
  assign pready    = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_color <= DEFAULT_COLOR;
    end else if (psel && penable && pwrite && pready && hit_color) begin
      text_color <= pwdata[7:0];
    end
  end

  assign prdata = hit_color ? PDATA_W'(text_color) : '0;

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for text_mode_terminal_writer, items and results on valid/stall
// keeps a shadow screen, cursor and text colour, predicts every result; needs tmtw_pkg and the rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tmtw_pkg::*;

  localparam int COLUMNS         = 80;
  localparam int ROWS            = 25;
  localparam int CELL_TOTAL      = COLUMNS * ROWS;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int PHASE_ITEMS     = 270;

  localparam logic [1:0]         ACT_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};
  // first word past the only register
  localparam logic [PADDR_W-1:0] SPARE_ADDR = COLOR_ADDR + 3'd4;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] char_code;
    logic [7:0] cell_color;
    logic [6:0] column;
    logic [4:0] row;
  } term_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_column;
    logic        scrolled;
  } term_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               item_valid   = 1'b0;
  logic               item_stall;
  logic [1:0]         action       = '0;
  logic [7:0]         char_code    = '0;
  logic [7:0]         cell_color   = '0;
  logic [6:0]         column       = '0;
  logic [4:0]         row          = '0;
  logic               result_valid;
  logic               result_stall = 1'b0;
  logic [15:0]        cell_value;
  logic [4:0]         cursor_row;
  logic [6:0]         cursor_column;
  logic               scrolled;
  logic               psel         = 1'b0;
  logic               penable      = 1'b0;
  logic               pwrite       = 1'b0;
  logic [PADDR_W-1:0] paddr        = '0;
  logic [PDATA_W-1:0] pwdata       = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  text_mode_terminal_writer #(
    .COLUMNS(COLUMNS),
    .ROWS   (ROWS)
  ) dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow of the terminal
  logic [15:0] shadow_grid [0:CELL_TOTAL-1];
  int          cur_row;
  int          cur_col;
  logic [7:0]  shadow_color;

  term_item_t   terminal_items [$];
  term_result_t awaited_cells [$];

  term_item_t staged_item;
  logic       have_item   = 1'b0;
  logic       item_taken  = 1'b0;
  int         gap_left    = 0;
  int         stall_left  = 0;
  bit         send_quiet  = 1'b0;
  bit         recv_quiet  = 1'b0;
  int         idle_cycles = 0;
  int         fail_count  = 0;

  function automatic term_item_t mk_item(input logic [1:0] act, input logic [7:0] ch,
                                         input logic [7:0] color, input logic [6:0] col,
                                         input logic [4:0] rw);
    term_item_t it;
    it.action     = act;
    it.char_code  = ch;
    it.cell_color = color;
    it.column     = col;
    it.row        = rw;
    return it;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap(input bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // works one item through the shadow terminal and queues the awaited result
  task automatic apply_to_shadow_screen(input term_item_t it);
    term_result_t res;
    logic         hit;
    res = '0;
    hit = (it.column < COLUMNS) && (it.row < ROWS);
    case (it.action)
      ACT_PUT_CHAR: begin
        if (it.char_code == NEWLINE_CODE) begin
          cur_col = 0;
          if (cur_row < ROWS) cur_row++;
        end else begin
          if (cur_row >= ROWS) begin
            for (int i = 0; i < CELL_TOTAL - COLUMNS; i++)
              shadow_grid[i] = shadow_grid[i + COLUMNS];
            for (int i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
              shadow_grid[i] = {shadow_color, BLANK_CODE};
            cur_row = ROWS - 1;
            res.scrolled = 1'b1;
          end
          res.cell_value = {shadow_color, it.char_code};
          shadow_grid[cur_row * COLUMNS + cur_col] = res.cell_value;
          cur_col++;
          if (cur_col >= COLUMNS) begin
            cur_col = 0;
            cur_row++;
          end
        end
      end
      ACT_PUT_CELL: begin
        if (hit) begin
          res.cell_value = {it.cell_color, it.char_code};
          shadow_grid[it.row * COLUMNS + it.column] = res.cell_value;
        end
      end
      ACT_READ: begin
        if (hit) res.cell_value = shadow_grid[it.row * COLUMNS + it.column];
      end
      default: ;
    endcase
    res.cursor_row    = 5'(cur_row);
    res.cursor_column = 7'(cur_col);
    awaited_cells.push_back(res);
  endtask

  // item driver, inputs change on the falling edge
  always @(negedge clk) begin : item_driver
    logic next_valid;
    next_valid = item_valid;
    if (item_valid && item_taken) begin
      next_valid = 1'b0;
      have_item  = 1'b0;
    end
    if (!have_item && terminal_items.size() > 0) begin
      staged_item = terminal_items.pop_front();
      have_item   = 1'b1;
      if ($urandom_range(0, 39) == 0) send_quiet = !send_quiet;
      gap_left = pick_gap(send_quiet);
    end
    if (have_item && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else begin
        next_valid = 1'b1;
        action     <= staged_item.action;
        char_code  <= staged_item.char_code;
        cell_color <= staged_item.cell_color;
        column     <= staged_item.column;
        row        <= staged_item.row;
      end
    end
    item_valid <= next_valid;
  end

  always @(negedge clk) begin : result_stall_driver
    if ($urandom_range(0, 199) == 0) recv_quiet = !recv_quiet;
    if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap(recv_quiet);
    end
  end

  // monitor, everything sampled on the rising edge
  always @(posedge clk) begin : monitor
    term_result_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (result_valid && !result_stall) begin
        if (awaited_cells.size() == 0) begin
          $error("result with no item awaiting it: cell_value %h", cell_value);
          fail_count++;
        end else begin
          want = awaited_cells.pop_front();
          if (cell_value !== want.cell_value) begin
            $error("cell_value expected %h got %h", want.cell_value, cell_value);
            fail_count++;
          end
          if (cursor_row !== want.cursor_row) begin
            $error("cursor_row expected %0d got %0d", want.cursor_row, cursor_row);
            fail_count++;
          end
          if (cursor_column !== want.cursor_column) begin
            $error("cursor_column expected %0d got %0d", want.cursor_column, cursor_column);
            fail_count++;
          end
          if (scrolled !== want.scrolled) begin
            $error("scrolled expected %b got %b", want.scrolled, scrolled);
            fail_count++;
          end
        end
      end
      if (item_valid && !item_stall) begin
        item_taken = 1'b1;
        apply_to_shadow_screen(mk_item(action, char_code, cell_color, column, row));
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if ((item_valid && !item_stall) || (result_valid && !result_stall) || (psel && penable))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                            input logic [PDATA_W-1:0] wdata, output logic [PDATA_W-1:0] rdata);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    if (wr && addr == COLOR_ADDR) shadow_color = wdata[7:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_text_color();
    logic [PDATA_W-1:0] rd;
    apb_access(1'b0, COLOR_ADDR, '0, rd);
    if (rd[7:0] !== shadow_color) begin
      $error("text_color expected %h got %h", shadow_color, rd[7:0]);
      fail_count++;
    end
  endtask

  task automatic wait_for_idle();
    while (terminal_items.size() != 0 || have_item || awaited_cells.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random_traffic(input int count);
    int         pushed;
    int         kind;
    int         len;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] rw;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        // a line of text, long ones wrap
        len = $urandom_range(1, 100);
        repeat (len) begin
          do ch = 8'($urandom_range(0, 255)); while (ch == NEWLINE_CODE);
          terminal_items.push_back(mk_item(ACT_PUT_CHAR, ch, 8'($urandom_range(0, 255)),
                                           7'($urandom_range(0, 127)),
                                           5'($urandom_range(0, 31))));
        end
        pushed += len;
        if ($urandom_range(0, 1)) begin
          terminal_items.push_back(mk_item(ACT_PUT_CHAR, NEWLINE_CODE,
                                           8'($urandom_range(0, 255)),
                                           7'($urandom_range(0, 127)),
                                           5'($urandom_range(0, 31))));
          pushed++;
        end
      end else if (kind < 50) begin
        len = $urandom_range(1, 30);
        repeat (len)
          terminal_items.push_back(mk_item(ACT_PUT_CHAR, NEWLINE_CODE,
                                           8'($urandom_range(0, 255)),
                                           7'($urandom_range(0, 127)),
                                           5'($urandom_range(0, 31))));
        pushed += len;
      end else if (kind < 70) begin
        // cell write then read it back
        col = 7'($urandom_range(0, COLUMNS - 1));
        rw  = 5'($urandom_range(0, ROWS - 1));
        terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)), col, rw));
        terminal_items.push_back(mk_item(ACT_READ, 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)), col, rw));
        pushed += 2;
      end else if (kind < 85) begin
        terminal_items.push_back(mk_item(ACT_READ, 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)),
                                         7'($urandom_range(0, COLUMNS - 1)),
                                         5'($urandom_range(0, ROWS - 1))));
        pushed++;
      end else begin
        terminal_items.push_back(mk_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                                         8'($urandom_range(0, 255)),
                                         7'($urandom_range(0, 127)),
                                         5'($urandom_range(0, 31))));
        pushed++;
      end
    end
  endtask

  initial begin : stimulus
    logic [PDATA_W-1:0] rd;
    logic [7:0]         phase_color;
    for (int i = 0; i < CELL_TOTAL; i++) shadow_grid[i] = {DEFAULT_COLOR, BLANK_CODE};
    cur_row      = 0;
    cur_col      = 0;
    shadow_color = DEFAULT_COLOR;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // register holds its reset value, clearing pass may still be running
    check_text_color();

    // corners, out of range positions, the unused action, plain characters
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
    terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'hFF, 8'hFF, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'h00, 8'h00, 7'd79, 5'd24));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_READ, 8'hFF, 8'hFF, 7'd79, 5'd24));
    terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'h55, 8'hAA, 7'd80, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'hAA, 8'h55, 7'd0, 5'd25));
    terminal_items.push_back(mk_item(ACT_PUT_CELL, 8'hFF, 8'hFF, 7'd127, 5'd31));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd127, 5'd31));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd80, 5'd24));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd25));
    terminal_items.push_back(mk_item(ACT_UNUSED, 8'hFF, 8'hFF, 7'd127, 5'd31));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'h41, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'h00, 8'hFF, 7'd127, 5'd31));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'hFF, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, NEWLINE_CODE, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'h0B, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'h09, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    terminal_items.push_back(mk_item(ACT_UNUSED, 8'h00, 8'h00, 7'd0, 5'd0));
    wait_for_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       phase_color = 8'h00;
        1:       phase_color = 8'hFF;
        default: phase_color = 8'($urandom_range(0, 255));
      endcase
      apb_access(1'b1, COLOR_ADDR, {24'd0, phase_color}, rd);
      // a write to the unmapped word must leave the colour alone
      if (ph == 2) apb_access(1'b1, SPARE_ADDR, $urandom, rd);
      check_text_color();

      // run the cursor past the bottom, newline saturates, then one character scrolls
      repeat (ROWS + 2) terminal_items.push_back(mk_item(ACT_PUT_CHAR, NEWLINE_CODE,
                                                         8'h00, 7'd0, 5'd0));
      terminal_items.push_back(mk_item(ACT_PUT_CHAR, 8'h5A, 8'h00, 7'd0, 5'd0));
      terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd0, 5'd23));
      terminal_items.push_back(mk_item(ACT_READ, 8'h00, 8'h00, 7'd79, 5'd24));
      queue_random_traffic(PHASE_ITEMS);
      wait_for_idle();
    end

    // let any stray result show up
    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
